[rtl/integer_to_ascii_formatter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Integer formatter assertion macros
// Concurrent check wrappers; they compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IAFMT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define IAFMT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define IAFMT_ASSERT(name, clk, rst_n, prop, msg)
`define IAFMT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

[rtl/iafmt_pkg.sv]
// ----------------------------------------------------------------------------
// Integer formatter package
// Shared constants, command/status types and the digit-to-ASCII function.
// ----------------------------------------------------------------------------
package iafmt_pkg;

    localparam int MAX_FIELD = 64;
    localparam int MAX_MD    = MAX_FIELD - 4;
    localparam int FIELD_W   = 7;
    localparam int MAG_W     = 64;
    localparam int DIGITS    = 22;
    localparam int SHIFT_W   = 5;
    localparam int BITCNT_W  = 6;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_0     = 2'd1;
    localparam logic [1:0] PFX_0LX   = 2'd2;
    localparam logic [1:0] PFX_0UX   = 2'd3;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic norm_step;
        logic calc1;
        logic calc2;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic norm_done;
        logic run_empty;
        logic emit_last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'b0, d};
        end else begin
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

[rtl/iafmt_ctrl.sv]
// ----------------------------------------------------------------------------
// Integer formatter controller
// Sequences load, conversion, normalization, layout and character output.
// ----------------------------------------------------------------------------
module iafmt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  iafmt_pkg::t_status i_status,
    output iafmt_pkg::t_cmd    o_cmd,
    output logic               o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CONV,
        S_NORM,
        S_CALC1,
        S_CALC2,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_status.is_dec ? S_CONV : S_NORM;
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_status.norm_done) begin
                    n_state = S_CALC1;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.run_empty) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/iafmt_dp.sv]
// ----------------------------------------------------------------------------
// Integer formatter datapath
// Digit register, shift-add-3 decimal converter, layout math, output word.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_defines.svh"

module iafmt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iafmt_pkg::t_cmd                     i_cmd,
    output iafmt_pkg::t_status                  o_status,
    input  logic [iafmt_pkg::MAG_W-1:0]         i_magnitude,
    input  logic [1:0]                          i_radix_sel,
    input  logic                                i_upper_case,
    input  logic                                i_is_negative,
    input  logic                                i_force_plus,
    input  logic                                i_left_justify,
    input  logic                                i_zero_pad,
    input  logic [iafmt_pkg::FIELD_W-1:0]       i_field_width,
    input  logic signed [iafmt_pkg::FIELD_W-1:0] i_min_digit_count,
    input  logic [1:0]                          i_prefix_sel,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [7:0]                          o_out_char,
    output logic                                o_last_char
);

    localparam int DG = iafmt_pkg::DIGITS;
    localparam int FW = iafmt_pkg::FIELD_W;

    // request fields
    logic [iafmt_pkg::MAG_W-1:0] r_mag;
    logic                        r_is_dec;
    logic                        r_upper;
    logic                        r_neg;
    logic                        r_sign_on;
    logic                        r_left;
    logic                        r_zero;
    logic [FW-1:0]               r_width;
    logic [FW-1:0]               r_md;
    logic [1:0]                  r_psel;

    // conversion state
    logic [3:0]                        r_dig [DG];
    logic [3:0]                        n_dig [DG];
    logic [3:0]                        w_adj [DG];
    logic [iafmt_pkg::BITCNT_W-1:0]    r_bitcnt;
    logic [iafmt_pkg::SHIFT_W-1:0]     r_shift;

    // layout
    logic [iafmt_pkg::SHIFT_W-1:0] r_len;
    logic [FW-1:0]                 r_nd;
    logic [FW-1:0]                 r_pad;
    logic [FW-1:0]                 r_b_lead;
    logic [FW-1:0]                 r_b_pfx;
    logic [FW-1:0]                 r_b_zero;
    logic [FW-1:0]                 r_b_dig;
    logic [FW-1:0]                 r_b_trail;
    logic [FW-1:0]                 r_last;
    logic                          r_empty;
    logic [FW-1:0]                 r_pos;

    // output word
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_lastc;

    logic [DG*4-1:0] w_hex_src;
    logic [DG*3-1:0] w_oct_src;
    logic            w_ld_hex;
    logic            w_out_free;

    assign w_hex_src  = {{(DG*4-iafmt_pkg::MAG_W){1'b0}}, i_magnitude};
    assign w_oct_src  = {{(DG*3-iafmt_pkg::MAG_W){1'b0}}, i_magnitude};
    assign w_ld_hex   = i_radix_sel[1];
    assign w_out_free = !r_valid || !i_out_stall;

    // digit register next value
    always_comb begin
        for (int i = 0; i < DG; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
            n_dig[i] = r_dig[i];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < DG; i++) begin
                if (i_radix_sel == iafmt_pkg::RADIX_DEC) begin
                    n_dig[i] = 4'd0;
                end else if (w_ld_hex) begin
                    n_dig[i] = w_hex_src[4*i +: 4];
                end else begin
                    n_dig[i] = {1'b0, w_oct_src[3*i +: 3]};
                end
            end
        end else if (i_cmd.conv_step) begin
            n_dig[0] = {w_adj[0][2:0], r_mag[iafmt_pkg::MAG_W-1]};
            for (int i = 1; i < DG; i++) begin
                n_dig[i] = {w_adj[i][2:0], w_adj[i-1][3]};
            end
        end else if (i_cmd.norm_step || (i_cmd.emit && r_pos >= r_b_dig && r_pos < r_b_trail)) begin
            n_dig[0] = 4'd0;
            for (int i = 1; i < DG; i++) begin
                n_dig[i] = r_dig[i-1];
            end
        end
    end

    // layout, first step
    logic                           w_zero_val;
    logic [iafmt_pkg::SHIFT_W-1:0]  w_len;
    logic [FW-1:0]                  w_md_sat;
    logic [FW-1:0]                  w_nd;
    logic [FW-1:0]                  w_plen;
    logic [FW-1:0]                  w_content;
    logic [FW-1:0]                  w_width_sat;

    always_comb begin
        w_zero_val = (r_dig[DG-1] == 4'd0);
        if (r_md == '0 && w_zero_val) begin
            w_len = '0;
        end else begin
            w_len = iafmt_pkg::SHIFT_W'(DG) - r_shift;
        end
        if (r_md[FW-1]) begin
            w_md_sat = '0;
        end else if (r_md > FW'(iafmt_pkg::MAX_MD)) begin
            w_md_sat = FW'(iafmt_pkg::MAX_MD);
        end else begin
            w_md_sat = r_md;
        end
        w_nd        = (FW'(w_len) > w_md_sat) ? FW'(w_len) : w_md_sat;
        w_plen      = (r_psel == iafmt_pkg::PFX_NONE) ? FW'(0) :
                      ((r_psel == iafmt_pkg::PFX_0) ? FW'(1) : FW'(2));
        w_content   = w_nd + w_plen + FW'(r_sign_on);
        w_width_sat = (r_width > FW'(iafmt_pkg::MAX_FIELD)) ? FW'(iafmt_pkg::MAX_FIELD)
                                                            : r_width;
    end

    // layout, second step: region boundaries along the run
    logic [FW-1:0] w_lead;
    logic [FW-1:0] w_b_pfx;
    logic [FW-1:0] w_b_zero;
    logic [FW-1:0] w_b_dig;
    logic [FW-1:0] w_b_trail;
    logic [FW-1:0] w_total;
    logic [FW-1:0] w_total_sat;

    always_comb begin
        w_lead      = (!r_left && !r_zero) ? r_pad : '0;
        w_b_pfx     = w_lead + FW'(r_sign_on);
        w_b_zero    = w_b_pfx + w_plen;
        w_b_dig     = w_b_zero + ((r_zero && !r_left) ? r_pad : '0) + (r_nd - FW'(r_len));
        w_b_trail   = w_b_dig + FW'(r_len);
        w_total     = w_b_trail + (r_left ? r_pad : '0);
        w_total_sat = (w_total > FW'(iafmt_pkg::MAX_FIELD)) ? FW'(iafmt_pkg::MAX_FIELD)
                                                            : w_total;
    end

    // character at the current run position
    logic [7:0] w_char;

    always_comb begin
        if (r_pos < r_b_lead) begin
            w_char = iafmt_pkg::CH_SPACE;
        end else if (r_pos < r_b_pfx) begin
            w_char = r_neg ? iafmt_pkg::CH_MINUS : iafmt_pkg::CH_PLUS;
        end else if (r_pos < r_b_zero) begin
            if (r_pos == r_b_pfx) begin
                w_char = iafmt_pkg::CH_ZERO;
            end else begin
                w_char = (r_psel == iafmt_pkg::PFX_0UX) ? iafmt_pkg::CH_UX : iafmt_pkg::CH_LX;
            end
        end else if (r_pos < r_b_dig) begin
            w_char = iafmt_pkg::CH_ZERO;
        end else if (r_pos < r_b_trail) begin
            w_char = iafmt_pkg::digit_char(r_dig[DG-1], r_upper);
        end else begin
            w_char = iafmt_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DG; i++) begin
            r_dig[i] <= n_dig[i];
        end
        if (i_cmd.load) begin
            r_mag     <= i_magnitude;
            r_is_dec  <= (i_radix_sel == iafmt_pkg::RADIX_DEC);
            r_upper   <= i_upper_case;
            r_neg     <= i_is_negative;
            r_sign_on <= i_is_negative || i_force_plus;
            r_left    <= i_left_justify;
            r_zero    <= i_zero_pad;
            r_width   <= i_field_width;
            r_md      <= i_min_digit_count;
            r_psel    <= i_prefix_sel;
            r_bitcnt  <= '0;
            r_shift   <= '0;
        end
        if (i_cmd.conv_step) begin
            r_mag    <= {r_mag[iafmt_pkg::MAG_W-2:0], 1'b0};
            r_bitcnt <= r_bitcnt + 1'b1;
        end
        if (i_cmd.norm_step) begin
            r_shift <= r_shift + 1'b1;
        end
        if (i_cmd.calc1) begin
            r_len <= w_len;
            r_nd  <= w_nd;
            r_pad <= (w_width_sat > w_content) ? w_width_sat - w_content : '0;
        end
        if (i_cmd.calc2) begin
            r_b_lead  <= w_lead;
            r_b_pfx   <= w_b_pfx;
            r_b_zero  <= w_b_zero;
            r_b_dig   <= w_b_dig;
            r_b_trail <= w_b_trail;
            r_last    <= w_total_sat - 1'b1;
            r_empty   <= (w_total == '0);
            r_pos     <= '0;
        end
        if (i_cmd.emit) begin
            r_pos   <= r_pos + 1'b1;
            r_char  <= w_char;
            r_lastc <= (r_pos == r_last);
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.is_dec    = r_is_dec;
    assign o_status.conv_done = (r_bitcnt == '1);
    assign o_status.norm_done = (r_dig[DG-1] != 4'd0) ||
                                (r_shift == iafmt_pkg::SHIFT_W'(DG - 1));
    assign o_status.run_empty = r_empty;
    assign o_status.emit_last = (r_pos == r_last);
    assign o_status.out_free  = w_out_free;

    assign o_out_valid = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_lastc;

    `IAFMT_ASSERT(a_emit_into_free_slot, i_clk, i_rst_n, i_cmd.emit |-> w_out_free,
                  "character emitted over a waiting output word")
    `IAFMT_ASSERT(a_emit_within_run, i_clk, i_rst_n, i_cmd.emit |-> (r_pos <= r_last),
                  "emit position beyond end of run")
    `IAFMT_NEVER(a_conv_only_decimal, i_clk, i_rst_n, i_cmd.conv_step && !r_is_dec,
                 "decimal conversion step on a non-decimal request")

endmodule

[rtl/integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// printf-style integer field formatter producing one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one request word: a 64-bit
//   magnitude plus radix, case, sign, justification, padding, field width,
//   minimum digit count and prefix controls. Output channel (o_out_valid /
//   i_out_stall) returns the character run one word at a time; o_last_char
//   marks the final character. A zero value with minimum digit count 0 and
//   nothing else to print returns no word at all.
//   Sequence: a setup state after acceptance, then 64 shift-add-3 steps for
//   decimal only, digit normalization, layout math in the CALC1 and CALC2
//   states, then one character per cycle while the receiver does not stall
//   (up to 64 characters). The decimal converter and the serial character
//   walk dominate the worst case from acceptance to the next acceptance.
//   One request is in flight at a time: o_in_stall is high from acceptance
//   until its last character is loaded into the output register, so the next
//   request is taken while that last word still waits for the receiver.
//   When the receiver stalls, the output word holds and the walk pauses.
//   Reset (synchronous, active low) returns to idle and drops any output word.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [iafmt_pkg::MAG_W-1:0]          i_magnitude,
    input  logic [1:0]                           i_radix_sel,
    input  logic                                 i_upper_case,
    input  logic                                 i_is_negative,
    input  logic                                 i_force_plus,
    input  logic                                 i_left_justify,
    input  logic                                 i_zero_pad,
    input  logic [iafmt_pkg::FIELD_W-1:0]        i_field_width,
    input  logic signed [iafmt_pkg::FIELD_W-1:0] i_min_digit_count,
    input  logic [1:0]                           i_prefix_sel,
    // character channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [7:0]                           o_out_char,
    output logic                                 o_last_char
);

    iafmt_pkg::t_cmd    w_cmd;
    iafmt_pkg::t_status w_status;
    logic               w_busy;

    // sequencer: hold off new requests while one is in progress
    iafmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // digit conversion, layout and the output word register
    iafmt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_magnitude       (i_magnitude),
        .i_radix_sel       (i_radix_sel),
        .i_upper_case      (i_upper_case),
        .i_is_negative     (i_is_negative),
        .i_force_plus      (i_force_plus),
        .i_left_justify    (i_left_justify),
        .i_zero_pad        (i_zero_pad),
        .i_field_width     (i_field_width),
        .i_min_digit_count (i_min_digit_count),
        .i_prefix_sel      (i_prefix_sel),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_out_char        (o_out_char),
        .o_last_char       (o_last_char)
    );

    assign o_in_stall = w_busy;

endmodule
